[src/vlpd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vlpd_pkg
// Shared types and constants of the varint length-prefixed deframer.
// ----------------------------------------------------------------------------
package vlpd_pkg;

    localparam int unsigned LEN_W  = 30;
    localparam int unsigned POS_W  = 32;
    localparam int unsigned BYTE_W = 8;

    typedef enum logic [1:0] {
        PH_FIRST   = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_HALTED  = 2'd3
    } phase_t;

    localparam logic [1:0] KIND_LENGTH  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    typedef struct packed {
        logic [1:0]       kind;
        logic [LEN_W-1:0] value;
        logic             frame_end;
    } result_t;

endpackage
`default_nettype wire

[src/varint_length_prefixed_deframer_top.sv]
// Path: input register, combinational decode, result register; a stalled result
// register holds a result-producing byte in the input register.
// Throughput: one byte per cycle while the result register is not stalled; the decode
// state update and buffer bound compare are combinational.
// Reset: asynchronous, active low; clears buffer_length to 0, returns the
// decoder to awaiting a first header byte and empties both registers.
`default_nettype none
// ----------------------------------------------------------------------------
// varint_length_prefixed_deframer_top
// Splits a bounded byte stream into 1/2/4-byte length-prefixed frames.
// ----------------------------------------------------------------------------
module varint_length_prefixed_deframer_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [vlpd_pkg::POS_W-1:0]  cfg_wdata,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [vlpd_pkg::BYTE_W-1:0] in_byte,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [1:0]                       out_kind,
    output logic [vlpd_pkg::LEN_W-1:0]       out_value,
    output logic                             frame_end
);
    import vlpd_pkg::*;

    logic              take;
    logic              byte_valid;
    logic [BYTE_W-1:0] byte_data;
    logic              res_valid;
    logic              res_ready;
    result_t           res;

    vlpd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .take       (take),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    vlpd_decode u_dec (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .res_ready  (res_ready),
        .take       (take),
        .res_valid  (res_valid),
        .res        (res)
    );

    vlpd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_kind  (out_kind),
        .out_value (out_value),
        .frame_end (frame_end)
    );

endmodule
`default_nettype wire

[src/vlpd_in_stage.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vlpd_in_stage
// Input register: holds one byte until the decoder takes it.
// ----------------------------------------------------------------------------
module vlpd_in_stage (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [vlpd_pkg::BYTE_W-1:0] in_byte,
    input  wire logic                        take,
    output logic                             byte_valid,
    output logic [vlpd_pkg::BYTE_W-1:0]      byte_data
);
    import vlpd_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              load;

    assign in_stall = valid_reg && !take;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= in_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

endmodule
`default_nettype wire

[src/vlpd_decode.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vlpd_decode
// Frame state and per-byte decode: prefix assembly, payload count, bounds.
// ----------------------------------------------------------------------------
module vlpd_decode (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [vlpd_pkg::POS_W-1:0]  cfg_wdata,
    input  wire logic                        byte_valid,
    input  wire logic [vlpd_pkg::BYTE_W-1:0] byte_data,
    input  wire logic                        res_ready,
    output logic                             take,
    output logic                             res_valid,
    output vlpd_pkg::result_t                res
);
    import vlpd_pkg::*;

    phase_t           phase_reg;
    phase_t           phase_next;
    logic [1:0]       hdr_left_reg;
    logic [1:0]       hdr_left_next;
    logic [LEN_W-1:0] len_acc_reg;
    logic [LEN_W-1:0] len_acc_next;
    logic [LEN_W-1:0] pay_left_reg;
    logic [LEN_W-1:0] pay_left_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] buf_len_reg;

    logic [POS_W-1:0] pos_inc;
    logic [POS_W:0]   end_pos;
    logic             len_done;
    logic [LEN_W-1:0] len_val;
    logic [LEN_W-1:0] shifted;
    logic [1:0]       hdr_dec;
    logic [LEN_W-1:0] pay_dec;
    logic             has_res;
    result_t          res_c;

    assign pos_inc = pos_reg + POS_W'(1);
    assign shifted = {len_acc_reg[LEN_W-1-BYTE_W:0], byte_data};
    assign hdr_dec = hdr_left_reg - 2'd1;
    assign pay_dec = pay_left_reg - LEN_W'(1);
    // length plus bytes consumed must not pass the buffer end
    assign end_pos = {1'b0, pos_inc} + (POS_W+1)'(len_val);

    always_comb
    begin
        phase_next    = phase_reg;
        hdr_left_next = hdr_left_reg;
        len_acc_next  = len_acc_reg;
        pay_left_next = pay_left_reg;
        pos_next      = pos_reg;
        has_res       = 1'b0;
        res_c         = '0;
        len_done      = 1'b0;
        len_val       = LEN_W'(byte_data[6:0]);

        case (phase_reg)
            PH_FIRST:
            begin
                len_done = !byte_data[7];
                len_val  = LEN_W'(byte_data[6:0]);
            end
            PH_HEADER:
            begin
                len_done = (hdr_dec == 2'd0);
                len_val  = shifted;
            end
            PH_PAYLOAD:
            begin
                len_done = 1'b0;
                len_val  = shifted;
            end
            default:
            begin
                len_done = 1'b0;
                len_val  = shifted;
            end
        endcase

        if (phase_reg == PH_HALTED)
        begin
            has_res = 1'b0;
        end
        else if (pos_reg >= buf_len_reg)
        begin
            has_res         = 1'b1;
            res_c.kind      = KIND_ERROR;
            res_c.frame_end = 1'b1;
            phase_next      = PH_HALTED;
        end
        else
        begin
            pos_next = pos_inc;
            if (len_done)
            begin
                has_res = 1'b1;
                if (end_pos > {1'b0, buf_len_reg})
                begin
                    res_c.kind      = KIND_ERROR;
                    res_c.frame_end = 1'b1;
                    phase_next      = PH_HALTED;
                end
                else
                begin
                    hdr_left_next   = 2'd0;
                    len_acc_next    = len_val;
                    res_c.kind      = KIND_LENGTH;
                    res_c.value     = len_val;
                    res_c.frame_end = (len_val == '0);
                    pay_left_next   = len_val;
                    phase_next      = (len_val == '0) ? PH_FIRST : PH_PAYLOAD;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_FIRST:
                    begin
                        len_acc_next  = LEN_W'(byte_data[5:0]);
                        hdr_left_next = byte_data[6] ? 2'd3 : 2'd1;
                        phase_next    = PH_HEADER;
                    end
                    PH_HEADER:
                    begin
                        len_acc_next  = shifted;
                        hdr_left_next = hdr_dec;
                    end
                    PH_PAYLOAD:
                    begin
                        has_res         = 1'b1;
                        pay_left_next   = pay_dec;
                        res_c.kind      = KIND_PAYLOAD;
                        res_c.value     = LEN_W'(byte_data);
                        res_c.frame_end = (pay_dec == '0);
                        if (pay_dec == '0)
                        begin
                            phase_next = PH_FIRST;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    assign take      = byte_valid && (res_ready || !has_res);
    assign res_valid = byte_valid && has_res;
    assign res       = res_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_FIRST;
            hdr_left_reg <= 2'd0;
            len_acc_reg  <= '0;
            pay_left_reg <= '0;
            pos_reg      <= '0;
            buf_len_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                buf_len_reg <= cfg_wdata;
            end
            if (take)
            begin
                phase_reg    <= phase_next;
                hdr_left_reg <= hdr_left_next;
                len_acc_reg  <= len_acc_next;
                pay_left_reg <= pay_left_next;
                pos_reg      <= pos_next;
            end
        end
    end

    a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HALTED) |-> !res_valid)
        else $error("result produced while halted");

    a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (take && res_valid && res.kind == KIND_ERROR) |=> (phase_reg == PH_HALTED))
        else $error("error result did not halt decoder");

    a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (pay_left_reg != '0))
        else $error("payload phase with zero bytes left");

    a_header_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HEADER) |-> (hdr_left_reg != 2'd0))
        else $error("header phase with zero bytes left");

endmodule
`default_nettype wire

[src/vlpd_out_stage.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vlpd_out_stage
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module vlpd_out_stage (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       res_valid,
    input  wire vlpd_pkg::result_t          res,
    output logic                            res_ready,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [1:0]                      out_kind,
    output logic [vlpd_pkg::LEN_W-1:0]      out_value,
    output logic                            frame_end
);
    import vlpd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;
    logic    load;

    assign res_ready = !valid_reg || !out_stall;
    assign load      = res_valid && res_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = res_reg.kind;
    assign out_value = res_reg.value;
    assign frame_end = res_reg.frame_end;

endmodule
`default_nettype wire
